FILE: hdl/rdrp_pkg.sv
// Types and constants shared by the relative dial report pulser.
`default_nettype none

package rdrp_pkg;

  localparam int unsigned NumDials = 4;

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_HOST_READ = 2'd1,
    OP_TICK      = 2'd2
  } op_e;

  localparam logic signed [7:0] ACC_MAX    = 8'sd127;
  localparam logic signed [7:0] ACC_MIN    = -8'sd127;
  localparam logic [7:0]        BTN_BIT    = 8'h80;
  localparam logic [6:0]        STEP_MINUS = 7'h7F;
  localparam logic [6:0]        STEP_PLUS  = 7'h01;
  localparam logic [1:0]        PULSE_DN   = 2'b01;
  localparam logic [1:0]        PULSE_UP   = 2'b10;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [7:0] delta_0;
    logic signed [7:0] delta_1;
    logic signed [7:0] delta_2;
    logic signed [7:0] delta_3;
    logic [15:0]       autopilot_word;
    logic [23:0]       switch_bits;
    logic [3:0]        dial_buttons;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pulse_bits;
    logic [7:0]  dial_byte_0;
    logic [7:0]  dial_byte_1;
    logic [7:0]  dial_byte_2;
    logic [7:0]  dial_byte_3;
    logic [15:0] report_autopilot;
    logic [23:0] report_switches;
    logic        report_pending;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/rdrp_in_if.sv
// Input channel: valid/ready handshake carrying one sample or command item.
`default_nettype none

interface rdrp_in_if
  import rdrp_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/rdrp_out_if.sv
// Output channel: valid/ready handshake carrying one report snapshot.
`default_nettype none

interface rdrp_out_if
  import rdrp_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/rdrp_core.sv
// Dial accumulator state, pulse builder and report register update.
`default_nettype none

module rdrp_core
  import rdrp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire in_item_t  item_i,
  input  wire logic      slow_mode_i,
  output out_item_t      result_o
);

  logic signed [7:0] acc_q [NumDials];
  logic signed [7:0] acc_d [NumDials];
  logic [15:0]       auto_q, auto_d;
  logic [23:0]       sw_q, sw_d;
  logic [3:0]        btn_q, btn_d;
  logic [7:0]        built_q, built_d;
  logic [7:0]        rpt_pulse_q, rpt_pulse_d;
  logic [7:0]        rpt_dial_q [NumDials];
  logic [7:0]        rpt_dial_d [NumDials];
  logic [15:0]       rpt_auto_q, rpt_auto_d;
  logic [23:0]       rpt_sw_q, rpt_sw_d;
  logic              pending_q, pending_d;

  logic signed [7:0] delta [NumDials];
  logic signed [8:0] sum [NumDials];
  logic signed [7:0] acc_s [NumDials];
  logic [7:0]        cand_dial [NumDials];
  logic [7:0]        bits;
  logic              pend_s;
  logic              gen;
  logic              diff;

  assign delta[0] = item_i.delta_0;
  assign delta[1] = item_i.delta_1;
  assign delta[2] = item_i.delta_2;
  assign delta[3] = item_i.delta_3;

  always_comb begin
    for (int i = 0; i < NumDials; i++) begin
      sum[i]   = $signed({acc_q[i][7], acc_q[i]}) + $signed({delta[i][7], delta[i]});
      acc_s[i] = acc_q[i];
    end
    auto_d = auto_q;
    sw_d   = sw_q;
    btn_d  = btn_q;
    pend_s = pending_q;
    case (op_e'(item_i.operation))
      OP_SAMPLE: begin
        for (int i = 0; i < NumDials; i++) begin
          if (sum[i] < $signed({ACC_MIN[7], ACC_MIN})) begin
            acc_s[i] = ACC_MIN;
          end else if (sum[i] > $signed({ACC_MAX[7], ACC_MAX})) begin
            acc_s[i] = ACC_MAX;
          end else begin
            acc_s[i] = sum[i][7:0];
          end
        end
        auto_d = item_i.autopilot_word;
        sw_d   = item_i.switch_bits;
        btn_d  = item_i.dial_buttons;
      end
      OP_HOST_READ: begin
        pend_s = 1'b0;
      end
      default: begin
      end
    endcase

    // Pulses only while the host has read the last report and fast mode is on
    gen  = !pend_s && !slow_mode_i;
    bits = '0;
    for (int i = 0; i < NumDials; i++) begin
      acc_d[i]     = acc_s[i];
      cand_dial[i] = btn_d[i] ? BTN_BIT : 8'h00;
      // A dial that pulsed in the last build rests for one build
      if (gen && built_q[2*i +: 2] == 2'b00) begin
        if (acc_s[i] < 0) begin
          bits[2*i +: 2]    = PULSE_DN;
          cand_dial[i][6:0] = STEP_MINUS;
          acc_d[i]          = acc_s[i] + 8'sd1;
        end else if (acc_s[i] > 0) begin
          bits[2*i +: 2]    = PULSE_UP;
          cand_dial[i][6:0] = STEP_PLUS;
          acc_d[i]          = acc_s[i] - 8'sd1;
        end
      end
    end
    built_d = gen ? bits : built_q;

    diff = (built_d != rpt_pulse_q) || (auto_d != rpt_auto_q) || (sw_d != rpt_sw_q);
    for (int i = 0; i < NumDials; i++) begin
      if (cand_dial[i] != rpt_dial_q[i]) begin
        diff = 1'b1;
      end
    end

    rpt_pulse_d = diff ? built_d : rpt_pulse_q;
    rpt_auto_d  = diff ? auto_d  : rpt_auto_q;
    rpt_sw_d    = diff ? sw_d    : rpt_sw_q;
    for (int i = 0; i < NumDials; i++) begin
      rpt_dial_d[i] = diff ? cand_dial[i] : rpt_dial_q[i];
    end
    pending_d = pend_s || diff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDials; i++) begin
        acc_q[i]      <= '0;
        rpt_dial_q[i] <= '0;
      end
      auto_q      <= '0;
      sw_q        <= '0;
      btn_q       <= '0;
      built_q     <= '0;
      rpt_pulse_q <= '0;
      rpt_auto_q  <= '0;
      rpt_sw_q    <= '0;
      pending_q   <= 1'b1;
    end else if (fire_i) begin
      for (int i = 0; i < NumDials; i++) begin
        acc_q[i]      <= acc_d[i];
        rpt_dial_q[i] <= rpt_dial_d[i];
      end
      auto_q      <= auto_d;
      sw_q        <= sw_d;
      btn_q       <= btn_d;
      built_q     <= built_d;
      rpt_pulse_q <= rpt_pulse_d;
      rpt_auto_q  <= rpt_auto_d;
      rpt_sw_q    <= rpt_sw_d;
      pending_q   <= pending_d;
    end
  end

  assign result_o.pulse_bits       = rpt_pulse_d;
  assign result_o.dial_byte_0      = rpt_dial_d[0];
  assign result_o.dial_byte_1      = rpt_dial_d[1];
  assign result_o.dial_byte_2      = rpt_dial_d[2];
  assign result_o.dial_byte_3      = rpt_dial_d[3];
  assign result_o.report_autopilot = rpt_auto_d;
  assign result_o.report_switches  = rpt_sw_d;
  assign result_o.report_pending   = pending_d;

endmodule

`default_nettype wire

FILE: hdl/relative_dial_report_pulser_unit.sv
// Relative dial report pulser: input register, report update, result register.
// Usage:
//   in_if  (sink)  : one item per transfer: sample (deltas plus switch,
//                    autopilot and button fields), host read, or update tick.
//   out_if (source): one report snapshot per accepted item, in order.
//   cfg_we_i/cfg_wdata_i: slow_mode, written while the block is idle.
// Timing:
//   An item is captured in the input register on its transfer edge and its
//   result is loaded into the output register on the first edge at which
//   the output register is empty or being taken. The report update is one
//   pass of adds, saturation and compares on the state registers, so one
//   item per cycle is sustained while out_if.ready stays high.
// Reset:
//   Accumulators, latched fields and the report clear; the report is marked
//   pending, so no dial pulses come out until the first host read.
// Stall:
//   While out_if.ready is low the result holds; one more item may wait in
//   the input register, then in_if.ready drops until the result is taken.
`default_nettype none

module relative_dial_report_pulser_unit
  import rdrp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rdrp_in_if.sink   in_if,
  rdrp_out_if.source out_if,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i
);

  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  logic      slow_mode_q;
  logic      fire;
  logic      in_xfer;
  out_item_t result;

  assign fire        = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || fire;
  assign in_xfer     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      slow_mode_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        slow_mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_if.data;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  rdrp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (in_q),
    .slow_mode_i(slow_mode_q),
    .result_o   (result)
  );

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

endmodule

`default_nettype wire
